### hdl/tli_pkg.sv
// table linear interpolator: shared types and constants
// no dependencies
`default_nettype none
package tli_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

### hdl/tli_ram.sv
// table linear interpolator: breakpoint memory, time and value per entry
// uses tli_pkg; one write port, one read port, registered read
`default_nettype none
module tli_ram
  import tli_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [63:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [63:0]       rdata
);
  logic [63:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/tli_div.sv
// table linear interpolator: restoring divider, one quotient bit per cycle
// uses tli_pkg
`default_nettype none
module tli_div
  import tli_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic        busy;
  logic        done;
  logic [6:0]  cnt;
  logic [63:0] quo;
  logic [32:0] rem;
  logic [32:0] dsr;
  logic [33:0] trial;

  assign trial = {rem, quo[63]} - {1'b0, dsr};
  assign rsp = '{done: done, quotient: quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'd0;
        quo <= req.dividend;
        dsr <= req.divisor;
        rem <= '0;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/table_linear_interpolator_unit.sv
// load: written to the table on acceptance, no result; loads can follow every cycle while idle
// query: on an empty table the result is zero with table_empty set; clamped to the end
// value outside the breakpoint times, else a binary search for the pair, then the divider
// one query at a time; the next item is taken the cycle after its result is registered
// output register lets loads and the next query proceed while a result waits
// rst clears the count, controller and output; the table is undefined until written
`default_nettype none
module table_linear_interpolator_unit
  import tli_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [8:0]    cfg_wdata,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // entry_index, point_time, point_value, query_time
  input  wire logic [103:0]  s_axis_tdata,
  // op
  input  wire logic          s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // result_value
  output logic [31:0]        m_axis_tdata,
  // table_empty
  output logic               m_axis_tuser
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_RDHI = 8'b00000010, S_CHHI = 8'b00000100,
    S_CHLO = 8'b00001000, S_MID  = 8'b00010000, S_RDP  = 8'b00100000,
    S_DIV  = 8'b01000000, S_OUT  = 8'b10000000
  } state_t;

  state_t state;
  logic [8:0] entry_count;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] lo, hi, mid, span;
  logic signed [31:0] qt, t_lo, v_lo, t_hi, v_hi;
  logic neg;
  logic signed [31:0] wres;
  logic wempty;
  logic signed [31:0] res;
  logic res_empty;
  logic out_load;
  logic ram_we;
  logic [ADDR_W-1:0] raddr;
  logic [63:0] rdata;
  logic signed [31:0] rd_t, rd_v;
  logic div_start;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [32:0] dv_mag;
  logic [31:0] dt;
  logic [32:0] den;
  logic signed [33:0] sum;

  logic in_op;
  logic [7:0] in_idx;
  logic [31:0] in_pt, in_pv, in_qt;
  assign in_op  = s_axis_tuser;
  assign in_idx = s_axis_tdata[7:0];
  assign in_pt  = s_axis_tdata[39:8];
  assign in_pv  = s_axis_tdata[71:40];
  assign in_qt  = s_axis_tdata[103:72];

  assign rd_t = rdata[31:0];
  assign rd_v = rdata[63:32];
  assign s_axis_tready = (state == S_IDLE);
  assign ram_we = s_axis_tvalid && s_axis_tready && (in_op == OP_LOAD);
  assign m_axis_tdata = res;
  assign m_axis_tuser = res_empty;
  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);
  assign cnt = (entry_count > 9'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
                                               : COUNT_W'(entry_count);
  assign mid = lo + ((hi - lo) >> 1);
  assign span = hi - lo;

  always_comb begin
    unique case (state)
      S_RDHI:  raddr = ADDR_W'(hi);
      S_CHHI:  raddr = '0;
      S_MID:   raddr = ADDR_W'(mid);
      S_RDP:   raddr = ADDR_W'(hi);
      default: raddr = ADDR_W'(hi);
    endcase
  end

  tli_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(in_idx[ADDR_W-1:0]), .wdata({in_pv, in_pt}),
    .raddr(raddr), .rdata(rdata)
  );

  assign dt = 32'(qt - t_lo);
  assign den = 33'({t_hi[31], t_hi} - {t_lo[31], t_lo});
  always_comb begin
    logic signed [32:0] d;
    d = {v_hi[31], v_hi} - {v_lo[31], v_lo};
    dv_mag = d[32] ? 33'(-d) : 33'(d);
  end
  assign dreq = '{start: div_start, dividend: 64'(dv_mag) * 64'(dt), divisor: den};
  assign sum = neg ? ({{2{v_lo[31]}}, v_lo} - {1'b0, drsp.quotient[32:0]})
                   : ({{2{v_lo[31]}}, v_lo} + {1'b0, drsp.quotient[32:0]});
  // quotient never exceeds |dv| so 33 bits suffice

  tli_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
      res <= wres;
      res_empty <= wempty;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready && in_op == OP_QUERY) begin
            qt <= in_qt;
            if (cnt == '0) begin
              wres <= '0;
              wempty <= 1'b1;
              state <= S_OUT;
            end else begin
              wempty <= 1'b0;
              lo <= '0;
              hi <= cnt - 1'b1;
              state <= S_RDHI;
            end
          end
        end
        S_RDHI: state <= S_CHHI;
        S_CHHI: begin
          t_hi <= rd_t;
          v_hi <= rd_v;
          if (qt >= rd_t) begin
            wres <= rd_v;
            state <= S_OUT;
          end else begin
            state <= S_CHLO;
          end
        end
        S_CHLO: begin
          t_lo <= rd_t;
          v_lo <= rd_v;
          if (qt <= rd_t) begin
            wres <= rd_v;
            state <= S_OUT;
          end else if (span <= COUNT_W'(1)) begin
            state <= S_RDP;
          end else begin
            state <= S_MID;
          end
        end
        S_MID: begin
          state <= S_RDP;
        end
        S_RDP: begin
          // after S_MID rdata holds the mid entry, otherwise the pair is final
          if (span > COUNT_W'(1)) begin
            if (qt <= rd_t) begin
              hi <= mid;
              t_hi <= rd_t;
              v_hi <= rd_v;
              state <= (mid - lo > COUNT_W'(1)) ? S_MID : S_RDP;
            end else begin
              lo <= mid;
              t_lo <= rd_t;
              v_lo <= rd_v;
              state <= (hi - mid > COUNT_W'(1)) ? S_MID : S_RDP;
            end
          end else begin
            if ($signed(den) <= 33'sd0) begin
              wres <= v_lo;
              state <= S_OUT;
            end else begin
              neg <= v_hi < v_lo;
              div_start <= 1'b1;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            if (sum > 34'sd2147483647) wres <= 32'sh7fffffff;
            else if (sum < -34'sd2147483648) wres <= 32'sh80000000;
            else wres <= sum[31:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/tli_checker.sv
// table linear interpolator: port checker and bind
// uses tli_pkg and table_linear_interpolator_unit ports
`default_nettype none
module tli_checker
  import tli_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [31:0]  m_axis_tdata,
  input wire logic         m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result dropped or changed while stalled");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("empty table result not zero");
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD |=> s_axis_tready)
    else $error("not ready after load item");
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY |=> !s_axis_tready)
    else $error("ready while query in progress");
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind table_linear_interpolator_unit tli_checker u_tli_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
